>>> hdl/s2cd_pkg.sv
// ----------------------------------------------------------------------------
// s2cd_pkg
// Shared types, constants and the month length table for the seconds to
// calendar date and time converter.
// ----------------------------------------------------------------------------
package s2cd_pkg;

  localparam int unsigned SecW   = 32;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned LenW   = 9;
  localparam int unsigned YearW  = 12;
  localparam int unsigned RemW   = 6;

  localparam logic [YearW-1:0] EpochYear = 12'd2025;
  localparam logic [6:0]       EpochMod100 = 7'd25;
  localparam logic [8:0]       EpochMod400 = 9'd25;
  localparam logic [6:0]       Mod100Last  = 7'd99;
  localparam logic [8:0]       Mod400Last  = 9'd399;

  localparam logic [LenW-1:0] YearLenLeap = 9'd366;
  localparam logic [LenW-1:0] YearLenNorm = 9'd365;
  localparam logic [LenW-1:0] DivSec      = 9'd60;
  localparam logic [LenW-1:0] DivMin      = 9'd60;
  localparam logic [LenW-1:0] DivHour     = 9'd24;

  localparam logic [3:0] MonthFeb  = 4'd1;
  localparam logic [3:0] MonthLast = 4'd11;

  typedef enum logic [1:0] {
    STG_SEC  = 2'd0,
    STG_MIN  = 2'd1,
    STG_HOUR = 2'd2
  } stage_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_YEAR  = 5'b00100,
    ST_MONTH = 5'b01000,
    ST_SPARE = 5'b10000
  } state_e;

  function automatic logic [LenW-1:0] month_len(input logic [3:0] m, input logic leap);
    logic [LenW-1:0] len;
    begin
      case (m)
        4'd0:    len = 9'd31;
        4'd1:    len = leap ? 9'd29 : 9'd28;
        4'd2:    len = 9'd31;
        4'd3:    len = 9'd30;
        4'd4:    len = 9'd31;
        4'd5:    len = 9'd30;
        4'd6:    len = 9'd31;
        4'd7:    len = 9'd31;
        4'd8:    len = 9'd30;
        4'd9:    len = 9'd31;
        4'd10:   len = 9'd30;
        default: len = 9'd31;
      endcase
      return len;
    end
  endfunction

endpackage

>>> hdl/s2cd_subcmp.sv
// ----------------------------------------------------------------------------
// s2cd_subcmp
// Shared compare and subtract unit: one restoring divide step, one year
// step or one month step per use.
// ----------------------------------------------------------------------------
module s2cd_subcmp (
  input  logic [s2cd_pkg::DaysW-1:0] a_i,
  input  logic [s2cd_pkg::LenW-1:0]  b_i,
  output logic [s2cd_pkg::DaysW-1:0] diff_o,
  output logic                       ge_o
);
  import s2cd_pkg::*;

  logic [DaysW:0] diff;

  assign diff   = {1'b0, a_i} - {{(DaysW+1-LenW){1'b0}}, b_i};
  assign diff_o = diff[DaysW-1:0];
  assign ge_o   = ~diff[DaysW];

endmodule

>>> hdl/seconds_to_calendar_datetime.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar_datetime
// Converts seconds since 2025-01-01 00:00:00 to Gregorian date and time.
//
// Usage: drive elapsed_seconds_i and raise start; the beat is taken at the
// rising edge where start is high and busy is low. busy stays high while
// the conversion runs. The result beat is shown for exactly one cycle with
// done_o high; the receiver cannot stall it, so it must capture it then.
// busy falls in the same cycle that done_o is shown, so the next start may
// be taken at that edge.
//
// Operation: three restoring divisions by 60, 60 and 24, then a walk that
// consumes whole years (up to 136) and then months (up to 11), all through
// one shared compare and subtract unit.
// Throughput: one conversion at a time.
//
// Reset: asynchronous, active low; the block returns to idle and any
// conversion in progress is dropped without a result.
// ----------------------------------------------------------------------------
module seconds_to_calendar_datetime (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [s2cd_pkg::SecW-1:0]   elapsed_seconds_i,
  output logic                        done_o,
  output logic [s2cd_pkg::YearW-1:0]  cal_year_o,
  output logic [3:0]                  cal_month_o,
  output logic [4:0]                  cal_day_o,
  output logic [4:0]                  cal_hour_o,
  output logic [5:0]                  cal_minute_o,
  output logic [5:0]                  cal_second_o
);
  import s2cd_pkg::*;

  state_e           state_q, state_d;
  stage_e           stage_q, stage_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [SecW-1:0]  quo_q, quo_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [DaysW-1:0] days_q, days_d;
  logic [YearW-1:0] year_q, year_d;
  logic [6:0]       m100_q, m100_d;
  logic [8:0]       m400_q, m400_d;
  logic [3:0]       month_q, month_d;
  logic [RemW-1:0]  sec_q, sec_d, min_q, min_d;
  logic [4:0]       hour_q, hour_d;
  logic             done_q, done_d;
  logic [YearW-1:0] oyear_q, oyear_d;
  logic [3:0]       omonth_q, omonth_d;
  logic [4:0]       oday_q, oday_d;

  logic [DaysW-1:0] u_a, u_diff;
  logic [LenW-1:0]  u_b, div_b;
  logic             u_ge, leap;
  logic [RemW-1:0]  step_rem;
  logic [SecW-1:0]  step_quo;

  assign leap = ((year_q[1:0] == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);

  always_comb begin
    case (stage_q)
      STG_SEC:  div_b = DivSec;
      STG_MIN:  div_b = DivMin;
      default:  div_b = DivHour;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_DIV: begin
        u_a = {{(DaysW-RemW-1){1'b0}}, rem_q, quo_q[SecW-1]};
        u_b = div_b;
      end
      ST_YEAR: begin
        u_a = days_q;
        u_b = leap ? YearLenLeap : YearLenNorm;
      end
      default: begin
        u_a = days_q;
        u_b = month_len(month_q, leap);
      end
    endcase
  end

  s2cd_subcmp u_subcmp (
    .a_i    (u_a),
    .b_i    (u_b),
    .diff_o (u_diff),
    .ge_o   (u_ge)
  );

  assign step_rem = u_ge ? u_diff[RemW-1:0] : {rem_q[RemW-2:0], quo_q[SecW-1]};
  assign step_quo = {quo_q[SecW-2:0], u_ge};

  always_comb begin
    state_d  = state_q;
    stage_d  = stage_q;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    days_d   = days_q;
    year_d   = year_q;
    m100_d   = m100_q;
    m400_d   = m400_q;
    month_d  = month_q;
    sec_d    = sec_q;
    min_d    = min_q;
    hour_d   = hour_q;
    done_d   = 1'b0;
    oyear_d  = oyear_q;
    omonth_d = omonth_q;
    oday_d   = oday_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DIV;
          stage_d = STG_SEC;
          cnt_d   = 5'd0;
          quo_d   = elapsed_seconds_i;
          rem_d   = '0;
        end
      end
      ST_DIV: begin
        quo_d = step_quo;
        rem_d = step_rem;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          rem_d = '0;
          case (stage_q)
            STG_SEC: begin
              sec_d   = step_rem;
              stage_d = STG_MIN;
            end
            STG_MIN: begin
              min_d   = step_rem;
              stage_d = STG_HOUR;
            end
            default: begin
              hour_d  = step_rem[4:0];
              days_d  = step_quo[DaysW-1:0];
              year_d  = EpochYear;
              m100_d  = EpochMod100;
              m400_d  = EpochMod400;
              state_d = ST_YEAR;
            end
          endcase
        end
      end
      ST_YEAR: begin
        if (u_ge) begin
          days_d = u_diff;
          year_d = year_q + 12'd1;
          m100_d = (m100_q == Mod100Last) ? 7'd0 : m100_q + 7'd1;
          m400_d = (m400_q == Mod400Last) ? 9'd0 : m400_q + 9'd1;
        end else begin
          month_d = 4'd0;
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if ((month_q == MonthLast) || !u_ge) begin
          done_d   = 1'b1;
          oyear_d  = year_q;
          omonth_d = month_q + 4'd1;
          oday_d   = days_q[4:0] + 5'd1;
          state_d  = ST_IDLE;
        end else begin
          days_d  = u_diff;
          month_d = month_q + 4'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= STG_SEC;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    days_q   <= days_d;
    year_q   <= year_d;
    m100_q   <= m100_d;
    m400_q   <= m400_d;
    month_q  <= month_d;
    sec_q    <= sec_d;
    min_q    <= min_d;
    hour_q   <= hour_d;
    oyear_q  <= oyear_d;
    omonth_q <= omonth_d;
    oday_q   <= oday_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign cal_year_o   = oyear_q;
  assign cal_month_o  = omonth_q;
  assign cal_day_o    = oday_q;
  assign cal_hour_o   = hour_q;
  assign cal_minute_o = min_q;
  assign cal_second_o = sec_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == ST_IDLE))
    else $error("result shown while still converting");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((cal_month_o != 4'd0) && (cal_month_o <= 4'd12) && (cal_day_o != 5'd0)))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((cal_hour_o < 5'd24) && (cal_minute_o < 6'd60) && (cal_second_o < 6'd60)))
    else $error("time of day out of range");

endmodule
